[sv/ipacl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipacl_pkg: shared types and codes of the prefix access check unit
// request and response layouts, stored rule entry, sequencer states
// ----------------------------------------------------------------------------
package ipacl_pkg;

  // operation codes
  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  // table select for a load
  localparam logic LIST_DENY  = 1'b0;
  localparam logic LIST_ALLOW = 1'b1;

  // address family
  localparam logic FAM_IPV4 = 1'b0;
  localparam logic FAM_IPV6 = 1'b1;

  // longest legal prefix per family
  localparam logic [7:0] MAX_PREFIX_V4 = 8'd32;
  localparam logic [7:0] MAX_PREFIX_V6 = 8'd128;

  // response status codes
  localparam logic [1:0] STATUS_CHECK_DONE    = 2'd0;
  localparam logic [1:0] STATUS_RULE_WRITTEN  = 2'd1;
  localparam logic [1:0] STATUS_RULE_REJECTED = 2'd2;

  // configuration register indexes
  localparam logic [3:0] CFG_DENY_RULES_USED  = 4'd0;
  localparam logic [3:0] CFG_ALLOW_RULES_USED = 4'd1;
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 5;

  typedef struct packed {
    logic        operation;
    logic        list_select;
    logic [3:0]  rule_slot;
    logic        addr_family;
    logic [7:0]  prefix_bits;
    logic [63:0] addr_upper;
    logic [63:0] addr_lower;
  } in_req_t;

  typedef struct packed {
    logic       allowed;
    logic       deny_hit;
    logic [1:0] status;
  } out_rsp_t;

  // one stored rule: family, prefix length and the two network address halves
  typedef struct packed {
    logic        family;
    logic [7:0]  prefix_len;
    logic [63:0] net_upper;
    logic [63:0] net_lower;
  } rule_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WALK,
    ST_FINISH
  } acl_state_e;

endpackage : ipacl_pkg

[sv/ipacl_rule_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipacl_rule_ram: rule storage for both tables
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module ipacl_rule_ram
  import ipacl_pkg::*;
#(
  parameter int unsigned ADDR_W = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  rule_t             wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output rule_t             rdata_o
);

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  rule_t mem_q [DEPTH];
  rule_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : ipacl_rule_ram

[sv/ipacl_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipacl_match: prefix compare of one address against one rule
// family must agree and the leading prefix bits must be equal
// ----------------------------------------------------------------------------
module ipacl_match
  import ipacl_pkg::*;
(
  input  rule_t       rule_i,
  input  logic        family_i,
  input  logic [63:0] addr_upper_i,
  input  logic [63:0] addr_lower_i,
  output logic        hit_o
);

  logic [63:0] mask_upper;
  logic [63:0] mask_lower;
  logic [7:0]  low_len;

  always_comb begin
    low_len = rule_i.prefix_len - 8'd64;
    // top prefix bits of each half set
    if (rule_i.prefix_len >= 8'd64) begin
      mask_upper = '1;
    end else begin
      mask_upper = ~({64{1'b1}} >> rule_i.prefix_len);
    end
    if (rule_i.prefix_len <= 8'd64) begin
      mask_lower = '0;
    end else if (rule_i.prefix_len >= 8'd128) begin
      mask_lower = '1;
    end else begin
      mask_lower = ~({64{1'b1}} >> low_len);
    end
    hit_o = (rule_i.family == family_i)
         && (((addr_upper_i ^ rule_i.net_upper) & mask_upper) == '0)
         && (((addr_lower_i ^ rule_i.net_lower) & mask_lower) == '0);
  end

endmodule : ipacl_match

[sv/ip_prefix_acl_check_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_prefix_acl_check_unit: ipv4/ipv6 prefix access check
// deny and allow rule tables in one synchronous ram, walked one rule a cycle
// ----------------------------------------------------------------------------
// usage
//   request channel (in_valid_i/in_ready_o, in_req_i) carries a check or a
//   rule load; one response per request on out_valid_o/out_ready_i,
//   out_rsp_o. config channel (cfg_valid_i/cfg_ready_o) sets the number of
//   deny and allow rules in use; always ready, write only while idle.
//   a load answers from the load state once the response register is free,
//   and the next request is taken back in idle. a check answers once the
//   walk ends, and the next request is taken back in idle after that; the
//   walk is set by the single ram read port feeding the compare unit one
//   rule per cycle; a hit ends the walk early.
//   one request is worked on at a time; the response sits in an output
//   register, so the next request is taken while it waits.
//   reset clears the rule counts and all control state; table contents are
//   undefined until loaded. a stalled receiver holds the response register,
//   and a finished walk waits in the finish state until that register frees.
// ----------------------------------------------------------------------------
module ip_prefix_acl_check_unit
  import ipacl_pkg::*;
#(
  parameter int unsigned RULES_PER_LIST = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_req_t                in_req_i,
  // response channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_rsp_t               out_rsp_o,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // index into one table, count up to a full table
  localparam int unsigned IDX_W  = (RULES_PER_LIST > 1) ? $clog2(RULES_PER_LIST) : 1;
  localparam int unsigned CNT_W  = $clog2(RULES_PER_LIST + 1);
  localparam int unsigned ADDR_W = IDX_W + 1;

  // config registers
  logic [CFG_DATA_W-1:0] deny_used_q, allow_used_q;

  // sequencer
  acl_state_e     state_q, state_d;
  in_req_t        req_q, req_d;
  logic [CNT_W-1:0] n_deny_q, n_deny_d;
  logic [CNT_W-1:0] n_allow_q, n_allow_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic           phase_q, phase_d;   // table being walked
  logic           pend_q, pend_d;     // read data valid this cycle
  logic           res_allow_q, res_allow_d;
  logic           res_deny_q, res_deny_d;

  // response register
  logic           out_valid_q, out_valid_d;
  out_rsp_t       out_rsp_q, out_rsp_d;

  // ram and compare
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  rule_t             ram_wdata, ram_rdata;
  logic              rule_hit;

  logic             out_free;
  logic             load_ok;
  logic [CNT_W-1:0] walk_limit;
  logic             issue;

  // counts above the table size act as a full table
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_DATA_W-1:0] used);
    if (32'(used) > RULES_PER_LIST) begin
      return CNT_W'(RULES_PER_LIST);
    end
    return CNT_W'(used);
  endfunction

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deny_used_q  <= '0;
      allow_used_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_DENY_RULES_USED) begin
        deny_used_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_ALLOW_RULES_USED) begin
        allow_used_q <= cfg_data_i;
      end
    end
  end

  // ---------------------------------------------------------------------
  // rule storage and compare
  // ---------------------------------------------------------------------
  // load legality: prefix within family limit, slot inside the table
  assign load_ok = ((req_q.addr_family == FAM_IPV6) ? (req_q.prefix_bits <= MAX_PREFIX_V6)
                                                    : (req_q.prefix_bits <= MAX_PREFIX_V4))
                && (32'(req_q.rule_slot) < RULES_PER_LIST);

  assign ram_waddr = {req_q.list_select, IDX_W'(req_q.rule_slot)};
  assign ram_wdata = '{family:     req_q.addr_family,
                       prefix_len: req_q.prefix_bits,
                       net_upper:  req_q.addr_upper,
                       net_lower:  req_q.addr_lower};
  assign ram_raddr = {phase_q, idx_q[IDX_W-1:0]};

  ipacl_rule_ram #(
    .ADDR_W (ADDR_W)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ipacl_match u_match (
    .rule_i       (ram_rdata),
    .family_i     (req_q.addr_family),
    .addr_upper_i (req_q.addr_upper),
    .addr_lower_i (req_q.addr_lower),
    .hit_o        (rule_hit)
  );

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  assign out_free   = !out_valid_q || out_ready_i;
  assign walk_limit = (phase_q == LIST_ALLOW) ? n_allow_q : n_deny_q;
  assign issue      = (idx_q < walk_limit);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    n_deny_d    = n_deny_q;
    n_allow_d   = n_allow_q;
    idx_d       = idx_q;
    phase_d     = phase_q;
    pend_d      = pend_q;
    res_allow_d = res_allow_q;
    res_deny_d  = res_deny_q;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    in_ready_o  = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d       = in_req_i;
          n_deny_d    = clamp_count(deny_used_q);
          n_allow_d   = clamp_count(allow_used_q);
          idx_d       = '0;
          phase_d     = LIST_DENY;
          pend_d      = 1'b0;
          res_allow_d = 1'b0;
          res_deny_d  = 1'b0;
          state_d     = (in_req_i.operation == OP_LOAD) ? ST_LOAD : ST_WALK;
        end
      end

      ST_LOAD: begin
        if (out_free) begin
          ram_we           = load_ok;
          out_valid_d      = 1'b1;
          out_rsp_d.allowed  = 1'b0;
          out_rsp_d.deny_hit = 1'b0;
          out_rsp_d.status   = load_ok ? STATUS_RULE_WRITTEN : STATUS_RULE_REJECTED;
          state_d          = ST_IDLE;
        end
      end

      ST_WALK: begin
        if (pend_q && rule_hit) begin
          // first hit decides: deny refuses, allow permits
          pend_d = 1'b0;
          if (phase_q == LIST_DENY) begin
            res_deny_d = 1'b1;
          end else begin
            res_allow_d = 1'b1;
          end
          state_d = ST_FINISH;
        end else if (!issue && !pend_q) begin
          // table exhausted without a hit
          if (phase_q == LIST_DENY && n_allow_q != '0) begin
            phase_d = LIST_ALLOW;
            idx_d   = '0;
          end else begin
            state_d = ST_FINISH;
          end
        end else begin
          ram_re = issue;
          pend_d = issue;
          if (issue) begin
            idx_d = idx_q + CNT_W'(1);
          end
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_rsp_d.allowed  = res_allow_q;
          out_rsp_d.deny_hit = res_deny_q;
          out_rsp_d.status   = STATUS_CHECK_DONE;
          state_d            = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request, walk position and response payload
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    n_deny_q    <= n_deny_d;
    n_allow_q   <= n_allow_d;
    idx_q       <= idx_d;
    phase_q     <= phase_d;
    res_allow_q <= res_allow_d;
    res_deny_q  <= res_deny_d;
    out_rsp_q   <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // one request in flight: no acceptance in the cycle after one
  a_single_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // a deny hit never comes with permission
  a_deny_refuses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.allowed && out_rsp_o.deny_hit))
    else $error("response both allowed and deny hit");

  // load responses carry no check verdict
  a_load_no_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status != STATUS_CHECK_DONE)
      |-> (!out_rsp_o.allowed && !out_rsp_o.deny_hit))
    else $error("load response with check flags set");

  // read data is only expected during a table walk
  a_pend_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_WALK))
    else $error("outstanding rule read outside the walk");

endmodule : ip_prefix_acl_check_unit
